@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the rasteriser core modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked while out of reset
`define ASSERT_SYNC(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_SYNC(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/core/mlr_pkg.sv @@
// ---------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants of the midpoint line rasteriser core.
// ---------------------------------------------------------------------------
package mlr_pkg;

  localparam int FIELD_BITS     = 6;
  localparam int COLOR_BITS     = 24;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;
  localparam int QUEUE_CNT_BITS = 2;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

  // packed segment word: sx, sy, colour, major, three decision terms, three flags
  function automatic int seg_bits(input int cb);
    return 6 * cb + 36;
  endfunction

endpackage

@@ rtl/core/mlr_front.sv @@
// ---------------------------------------------------------------------------
// mlr_front
// Classifies a segment: deltas, octant, major axis and decision terms.
// ---------------------------------------------------------------------------
module mlr_front #(
  parameter int COORD_BITS = 6
) (
  input  logic [mlr_pkg::FIELD_BITS-1:0]           start_x,
  input  logic [mlr_pkg::FIELD_BITS-1:0]           start_y,
  input  logic [mlr_pkg::FIELD_BITS-1:0]           end_x,
  input  logic [mlr_pkg::FIELD_BITS-1:0]           end_y,
  input  logic [mlr_pkg::COLOR_BITS-1:0]           pixel_color,
  output logic [mlr_pkg::seg_bits(COORD_BITS)-1:0] seg_word
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 3;

  typedef struct packed {
    logic [CB-1:0]                   sx;
    logic [CB-1:0]                   sy;
    logic [mlr_pkg::COLOR_BITS-1:0]  color;
    logic [CB-1:0]                   major;
    logic signed [DW-1:0]            dec;
    logic signed [DW-1:0]            inc_diag;
    logic signed [DW-1:0]            inc_straight;
    logic                            steep;
    logic                            step_x_pos;
    logic                            step_y_pos;
  } seg_t;

  seg_t seg;

  logic [CB-1:0]        sx, sy, ex, ey;
  logic [CB-1:0]        adx, ady, major, minor;
  logic                 x_pos, y_pos, steep;
  logic signed [DW-1:0] major_e, minor_e;

  always_comb begin
    sx      = start_x[CB-1:0];
    sy      = start_y[CB-1:0];
    ex      = end_x[CB-1:0];
    ey      = end_y[CB-1:0];
    x_pos   = ex > sx;
    y_pos   = ey > sy;
    adx     = x_pos ? ex - sx : sx - ex;
    ady     = y_pos ? ey - sy : sy - ey;
    steep   = ady > adx;
    major   = steep ? ady : adx;
    minor   = steep ? adx : ady;
    major_e = DW'(major);
    minor_e = DW'(minor);

    seg.sx           = sx;
    seg.sy           = sy;
    seg.color        = pixel_color;
    seg.major        = major;
    seg.dec          = (minor_e <<< 1) - major_e;
    seg.inc_diag     = (minor_e - major_e) <<< 1;
    seg.inc_straight = minor_e <<< 1;
    seg.steep        = steep;
    seg.step_x_pos   = x_pos;
    seg.step_y_pos   = y_pos;
  end

  assign seg_word = seg;

endmodule

@@ rtl/core/mlr_queue.sv @@
// ---------------------------------------------------------------------------
// mlr_queue
// Two-entry queue of classified segments between front and back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlr_queue #(
  parameter int WIDTH = 72
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   din,
  input  logic               pop,
  output logic [WIDTH-1:0]   dout,
  output mlr_pkg::qstat_t    status
);

  localparam int PB = mlr_pkg::QUEUE_PTR_BITS;
  localparam int NB = mlr_pkg::QUEUE_CNT_BITS;

  logic [WIDTH-1:0] entries [mlr_pkg::QUEUE_DEPTH];
  logic [PB-1:0]    wr_ptr, rd_ptr;
  logic [NB-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(mlr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(mlr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign dout             = entries[rd_ptr];
  assign status.full      = count == NB'(mlr_pkg::QUEUE_DEPTH);
  assign status.not_empty = count != '0;

  `ASSERT_SYNC(a_pop_not_empty, clk, rst, pop |-> count != '0)
  `ASSERT_SYNC(a_fill_tracks, clk, rst, (push && !pop) |=> count == $past(count) + 1'b1)
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> count == '0)

endmodule

@@ rtl/core/mlr_back.sv @@
// ---------------------------------------------------------------------------
// mlr_back
// Midpoint stepper: walks one segment, one pixel word per unstalled cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlr_back #(
  parameter int COORD_BITS = 6
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [mlr_pkg::seg_bits(COORD_BITS)-1:0] seg_word,
  input  logic                                     seg_ready,
  output logic                                     seg_pop,
  output logic                                     pix_valid,
  input  logic                                     pix_stall,
  output logic [mlr_pkg::FIELD_BITS-1:0]           pixel_x,
  output logic [mlr_pkg::FIELD_BITS-1:0]           pixel_y,
  output logic [mlr_pkg::COLOR_BITS-1:0]           out_color,
  output logic                                     last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 3;
  localparam int FB = mlr_pkg::FIELD_BITS;

  typedef struct packed {
    logic [CB-1:0]                   sx;
    logic [CB-1:0]                   sy;
    logic [mlr_pkg::COLOR_BITS-1:0]  color;
    logic [CB-1:0]                   major;
    logic signed [DW-1:0]            dec;
    logic signed [DW-1:0]            inc_diag;
    logic signed [DW-1:0]            inc_straight;
    logic                            steep;
    logic                            step_x_pos;
    logic                            step_y_pos;
  } seg_t;

  seg_t seg;
  assign seg = seg_word;

  mlr_pkg::back_state_t state, state_next;

  logic [CB-1:0]                  x, y, cnt;
  logic signed [DW-1:0]           dec, inc_diag, inc_straight;
  logic                           steep, step_x_pos, step_y_pos;
  logic [mlr_pkg::COLOR_BITS-1:0] color;

  logic fire, last, load, step, diag;

  assign fire = (state == mlr_pkg::BACK_RUN) && !pix_stall;
  assign last = cnt == '0;
  assign diag = !dec[DW-1] && (dec != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      mlr_pkg::BACK_IDLE: begin
        if (seg_ready) state_next = mlr_pkg::BACK_RUN;
      end
      mlr_pkg::BACK_RUN: begin
        if (fire && last && !seg_ready) state_next = mlr_pkg::BACK_IDLE;
      end
      default: state_next = mlr_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    step = 1'b0;
    unique case (state)
      mlr_pkg::BACK_IDLE: begin
        load = seg_ready;
      end
      mlr_pkg::BACK_RUN: begin
        load = fire && last && seg_ready;
        step = fire && !last;
      end
      default: begin
        load = 1'b0;
        step = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlr_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x            <= seg.sx;
      y            <= seg.sy;
      color        <= seg.color;
      cnt          <= seg.major;
      dec          <= seg.dec;
      inc_diag     <= seg.inc_diag;
      inc_straight <= seg.inc_straight;
      steep        <= seg.steep;
      step_x_pos   <= seg.step_x_pos;
      step_y_pos   <= seg.step_y_pos;
    end else if (step) begin
      cnt <= cnt - 1'b1;
      dec <= dec + (diag ? inc_diag : inc_straight);
      if (!steep || diag) begin
        x <= step_x_pos ? x + 1'b1 : x - 1'b1;
      end
      if (steep || diag) begin
        y <= step_y_pos ? y + 1'b1 : y - 1'b1;
      end
    end
  end

  assign seg_pop    = load;
  assign pix_valid  = state == mlr_pkg::BACK_RUN;
  assign pixel_x    = FB'(x);
  assign pixel_y    = FB'(y);
  assign out_color  = color;
  assign last_pixel = last;

  `ASSERT_SYNC(a_load_runs, clk, rst, load |=> state == mlr_pkg::BACK_RUN)
  `ASSERT_SYNC(a_count_down, clk, rst, step |=> cnt == $past(cnt) - 1'b1)
  `ASSERT_SYNC(a_major_moves, clk, rst,
    (step && !steep) |=> x != $past(x))

endmodule

@@ rtl/core/midpoint_line_rasterizer_core.sv @@
// ---------------------------------------------------------------------------
// midpoint_line_rasterizer_core
// Midpoint line rasteriser, square tile, one pixel word per unstalled cycle.
// ---------------------------------------------------------------------------
// A segment word gives two endpoints and a colour; the core emits every pixel
// from start to end, both endpoints included, and flags the last. A segment
// has max(|dx|, |dy|) + 1 pixels, up to 2^COORD_BITS, walked by the stepper in
// the back end, which produces one pixel per cycle while pix_stall is low. A
// front end classifies each segment on acceptance and parks it in a two-entry
// queue, so new segments are taken while pixels of earlier ones still drain,
// and a segment queued before the last pixel goes follows with no idle cycle.
module midpoint_line_rasterizer_core #(
  parameter int COORD_BITS = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           seg_valid,
  output logic                           seg_stall,
  input  logic [mlr_pkg::FIELD_BITS-1:0] start_x,
  input  logic [mlr_pkg::FIELD_BITS-1:0] start_y,
  input  logic [mlr_pkg::FIELD_BITS-1:0] end_x,
  input  logic [mlr_pkg::FIELD_BITS-1:0] end_y,
  input  logic [mlr_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                           pix_valid,
  input  logic                           pix_stall,
  output logic [mlr_pkg::FIELD_BITS-1:0] pixel_x,
  output logic [mlr_pkg::FIELD_BITS-1:0] pixel_y,
  output logic [mlr_pkg::COLOR_BITS-1:0] out_color,
  output logic                           last_pixel
);

  localparam int SW = mlr_pkg::seg_bits(COORD_BITS);

  logic [SW-1:0]   front_word, queue_word;
  logic            push, pop;
  mlr_pkg::qstat_t qstat;

  assign seg_stall = qstat.full;
  assign push      = seg_valid && !qstat.full;

  mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .pixel_color (pixel_color),
    .seg_word    (front_word)
  );

  mlr_queue #(.WIDTH(SW)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (front_word),
    .pop    (pop),
    .dout   (queue_word),
    .status (qstat)
  );

  mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .seg_word   (queue_word),
    .seg_ready  (qstat.not_empty),
    .seg_pop    (pop),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_color  (out_color),
    .last_pixel (last_pixel)
  );

endmodule
